// ===== rtl/core/bmls_pkg.sv =====
// Shared codes, types and key layout for the bounded multi-list store.
`timescale 1ns / 1ps
package bmls_pkg;

	typedef enum logic [3:0] {
		ACT_CREATE          = 4'd0,
		ACT_APPEND          = 4'd1,
		ACT_POP             = 4'd2,
		ACT_REMOVE          = 4'd3,
		ACT_RESIZE          = 4'd4,
		ACT_COUNT           = 4'd5,
		ACT_READ            = 4'd6,
		ACT_READ_SORTED     = 4'd7,
		ACT_READ_ALL        = 4'd8,
		ACT_READ_ALL_SORTED = 4'd9
	} act_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_BAD_POS      = 4'd1,
		ST_NO_LIST      = 4'd2,
		ST_EXISTS       = 4'd3,
		ST_BAD_SIZE     = 4'd4,
		ST_NO_MEMORY    = 4'd5,
		ST_FULL         = 4'd6,
		ST_EMPTY        = 4'd7,
		ST_MISSING      = 4'd8,
		ST_BAD_NEW_SIZE = 4'd9,
		ST_ALL_EMPTY    = 4'd10
	} status_t;

	typedef logic [4:0] cnt_t;
	typedef logic [3:0] num_t;

	typedef struct packed {
		logic    posok;
		logic    exists;
		cnt_t    cap;
		cnt_t    fill;
		cnt_t    new_fill;
		status_t status;
	} tbl_view_t;

	typedef struct packed {
		logic [31:0] v;
		logic [7:0]  idx;
	} key_t;

endpackage

// ===== rtl/core/bmls_cmp.sv =====
// Shared key compare: signed value first, buffer position second.
`timescale 1ns / 1ps
module bmls_cmp (
	input  bmls_pkg::key_t a,
	input  bmls_pkg::key_t b,
	output logic           lt
);
	import bmls_pkg::*;

	logic [39:0] ka;
	logic [39:0] kb;

	assign ka = {~a.v[31], a.v[30:0], a.idx};
	assign kb = {~b.v[31], b.v[30:0], b.idx};
	assign lt = (ka < kb);

endmodule

// ===== rtl/core/bmls_table.sv =====
// List table: existence, capacity and fill per list, with action checks.
`timescale 1ns / 1ps
module bmls_table #(
	parameter int NUM_LISTS    = 8,
	parameter int MAX_CAPACITY = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmls_pkg::num_t      num,
	input  logic [3:0]          act,
	input  logic signed [7:0]   amount,
	input  logic                commit,
	input  logic                dec,
	output bmls_pkg::tbl_view_t view
);
	import bmls_pkg::*;

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW = $clog2(MAX_CAPACITY + 1);

	logic          exists_q [NUM_LISTS];
	logic [CW-1:0] cap_q    [NUM_LISTS];
	logic [CW-1:0] fill_q   [NUM_LISTS];

	logic               posok;
	logic [LW-1:0]      li;
	logic               ex;
	logic [CW-1:0]      cap;
	logic [CW-1:0]      fill;
	logic signed [9:0]  nc;
	status_t            st;
	logic [CW-1:0]      nfill;

	assign posok = (num != '0) && (32'(num) <= NUM_LISTS);
	assign li    = posok ? LW'(num - 4'd1) : '0;
	assign ex    = exists_q[li];
	assign cap   = cap_q[li];
	assign fill  = fill_q[li];
	assign nc    = $signed({{(10-CW){1'b0}}, cap}) + $signed({{2{amount[7]}}, amount});

	always_comb begin
		st    = ST_OK;
		nfill = fill;
		if (act == ACT_CREATE) begin
			if (amount < 8'sd1) st = ST_BAD_SIZE;
			else if (!posok) st = ST_BAD_POS;
			else if (ex) st = ST_EXISTS;
			else if (amount > $signed(8'(MAX_CAPACITY))) st = ST_NO_MEMORY;
			else nfill = '0;
		end else if (act == ACT_READ_ALL || act == ACT_READ_ALL_SORTED
				|| act > ACT_READ_ALL_SORTED) begin
			st = ST_OK;
		end else if (!posok) begin
			st = ST_BAD_POS;
		end else if (!ex) begin
			st = ST_NO_LIST;
		end else begin
			unique case (act)
				ACT_APPEND: begin
					if (fill >= cap) st = ST_FULL;
					else nfill = fill + 1'b1;
				end
				ACT_POP: begin
					if (fill == '0) st = ST_EMPTY;
					else nfill = fill - 1'b1;
				end
				ACT_REMOVE, ACT_COUNT: begin
					if (fill == '0) st = ST_EMPTY;
				end
				ACT_RESIZE: begin
					if (nc < 10'sd1) st = ST_BAD_NEW_SIZE;
					else if (nc > $signed(10'(MAX_CAPACITY))) st = ST_NO_MEMORY;
					else if ($signed({{(10-CW){1'b0}}, fill}) > nc) nfill = nc[CW-1:0];
				end
				default: st = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				exists_q[i] <= 1'b0;
				cap_q[i]    <= '0;
				fill_q[i]   <= '0;
			end
		end else if (dec) begin
			fill_q[li] <= fill - 1'b1;
		end else if (commit && st == ST_OK) begin
			unique case (act)
				ACT_CREATE: begin
					exists_q[li] <= 1'b1;
					cap_q[li]    <= amount[CW-1:0];
					fill_q[li]   <= '0;
				end
				ACT_APPEND, ACT_POP: fill_q[li] <= nfill;
				ACT_RESIZE: begin
					cap_q[li]  <= nc[CW-1:0];
					fill_q[li] <= nfill;
				end
				default: ;
			endcase
		end
	end

	assign view.posok    = posok;
	assign view.exists   = ex;
	assign view.cap      = 5'(cap);
	assign view.fill     = 5'(fill);
	assign view.new_fill = 5'(nfill);
	assign view.status   = st;

endmodule

// ===== rtl/core/bounded_multi_list_store_top.sv =====
// Top level: command sequencer, element store and readout buffer.
//
//   channel | direction | fields
//   in      | sink      | action, list_number, value, amount
//   out     | source    | status, has_value, value_res, count, last
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Table actions decide, then emit; remove reads and compares each entry searched,
// then reads and writes each entry moved. Reads gather each element into a buffer,
// then read each plain result or select each sorted one via the single key compare.
// Reset clears the list table; the element store needs no clearing.
// A stalled output holds the sequencer in its result state.
`timescale 1ns / 1ps
module bounded_multi_list_store_top #(
	parameter int NUM_LISTS    = 8,
	parameter int MAX_CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         action,
	input  logic [3:0]         list_number,
	input  logic signed [31:0] value,
	input  logic signed [7:0]  amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         status,
	output logic               has_value,
	output logic signed [31:0] value_res,
	output logic [3:0]         count,
	output logic               last
);
	import bmls_pkg::*;

	localparam int DEPTH = NUM_LISTS * MAX_CAPACITY;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW    = $clog2(MAX_CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_RM_RD, S_RM_CMP, S_SH_RD, S_SH_WR, S_G_RD, S_G_WR,
		S_G_END, S_P_RD, S_P_OUT, S_Q_RD, S_Q_PREV, S_Q_BEST, S_Q_OUT, S_EMIT1
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [CW-1:0] j);
		addr_of = AW'(int'(l) * MAX_CAPACITY + int'(j));
	endfunction

	state_t            state_q;
	logic [3:0]        act_q;
	num_t              num_q;
	logic [31:0]       val_q;
	logic signed [7:0] amt_q;
	status_t           st_q;
	cnt_t              cnt_q;
	logic              all_q;
	logic              sorted_q;
	logic [LW-1:0]     gl_q;
	logic [CW-1:0]     ri_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     i_q;
	logic [NW-1:0]     k_q;
	key_t              best_q;
	key_t              prev_q;
	logic              have_best_q;
	logic              have_prev_q;

	logic              out_valid_q;
	status_t           status_q;
	logic              has_value_q;
	logic [31:0]       value_q;
	logic [3:0]        count_q;
	logic              last_q;

	logic [31:0]       store_mem [DEPTH];
	logic [31:0]       buf_mem   [DEPTH];
	logic [31:0]       store_rdata_q;
	logic [31:0]       buf_rdata_q;

	logic              store_re;
	logic [AW-1:0]     store_raddr;
	logic              store_we;
	logic [AW-1:0]     store_waddr;
	logic [31:0]       store_wdata;
	logic              buf_re;
	logic [AW-1:0]     buf_raddr;
	logic              buf_we;

	num_t              tbl_num;
	logic              tbl_dec;
	tbl_view_t         view;
	logic [LW-1:0]     li_c;
	logic              out_free;
	logic              emit_c;
	logic              list_end;
	logic              scan_more;
	key_t              cand;
	key_t              cmp_a;
	key_t              cmp_b;
	logic              cmp_lt;

	assign li_c     = LW'(num_q - 4'd1);
	assign out_free = !out_valid_q || out_ready;
	assign emit_c   = out_free && (state_q == S_P_OUT || state_q == S_Q_OUT
			|| state_q == S_EMIT1);
	assign in_ready = (state_q == S_IDLE);
	assign tbl_num  = (state_q == S_G_RD && all_q) ? 4'(gl_q) + 4'd1 : num_q;
	assign tbl_dec  = (state_q == S_SH_RD) && !(5'(ri_q) + 5'd1 < view.fill);
	assign list_end = !view.posok || !view.exists || (5'(ri_q) >= view.fill);
	assign scan_more = (i_q + 1'b1) < n_q;
	assign cand.v   = buf_rdata_q;
	assign cand.idx = 8'(i_q);
	assign cmp_a    = (state_q == S_Q_PREV) ? prev_q : cand;
	assign cmp_b    = (state_q == S_Q_PREV) ? cand : best_q;

	bmls_table #(
		.NUM_LISTS   (NUM_LISTS),
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.num   (tbl_num),
		.act   (act_q),
		.amount(amt_q),
		.commit(state_q == S_DECIDE),
		.dec   (tbl_dec),
		.view  (view)
	);

	bmls_cmp u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.lt(cmp_lt)
	);

	always_comb begin
		store_re    = 1'b0;
		store_raddr = '0;
		store_we    = 1'b0;
		store_waddr = '0;
		store_wdata = store_rdata_q;
		buf_re      = 1'b0;
		buf_raddr   = '0;
		buf_we      = 1'b0;
		unique case (state_q)
			S_DECIDE: begin
				store_we    = (act_q == ACT_APPEND) && (view.status == ST_OK);
				store_waddr = addr_of(li_c, view.fill[CW-1:0]);
				store_wdata = val_q;
			end
			S_RM_RD: begin
				store_re    = 1'b1;
				store_raddr = addr_of(li_c, ri_q);
			end
			S_SH_RD: begin
				store_re    = 1'b1;
				store_raddr = addr_of(li_c, CW'(ri_q + 1'b1));
			end
			S_SH_WR: begin
				store_we    = 1'b1;
				store_waddr = addr_of(li_c, ri_q);
			end
			S_G_RD: begin
				store_re    = !list_end;
				store_raddr = addr_of(gl_q, ri_q);
			end
			S_G_WR: begin
				buf_we = 1'b1;
			end
			S_P_RD: begin
				buf_re    = 1'b1;
				buf_raddr = AW'(k_q);
			end
			S_Q_RD: begin
				buf_re    = 1'b1;
				buf_raddr = AW'(i_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_waddr] <= store_wdata;
		if (store_re) store_rdata_q <= store_mem[store_raddr];
		if (buf_we) buf_mem[AW'(n_q)] <= store_rdata_q;
		if (buf_re) buf_rdata_q <= buf_mem[buf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			have_best_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit_c) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						num_q   <= list_number;
						val_q   <= value;
						amt_q   <= amount;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					st_q     <= view.status;
					cnt_q    <= (view.posok && act_q != ACT_READ_ALL
							&& act_q != ACT_READ_ALL_SORTED) ? view.new_fill : '0;
					ri_q     <= '0;
					n_q      <= '0;
					sorted_q <= (act_q == ACT_READ_SORTED) || (act_q == ACT_READ_ALL_SORTED);
					if (act_q == ACT_READ_ALL || act_q == ACT_READ_ALL_SORTED) begin
						all_q   <= 1'b1;
						gl_q    <= '0;
						state_q <= S_G_RD;
					end else if (view.status == ST_OK && view.posok && view.exists
							&& (act_q == ACT_READ || act_q == ACT_READ_SORTED)) begin
						all_q   <= 1'b0;
						gl_q    <= li_c;
						state_q <= S_G_RD;
					end else if (view.status == ST_OK && act_q == ACT_REMOVE) begin
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_EMIT1;
					end
				end
				S_RM_RD: state_q <= S_RM_CMP;
				S_RM_CMP: begin
					if (store_rdata_q == val_q) begin
						state_q <= S_SH_RD;
					end else if (5'(ri_q) + 5'd1 < view.fill) begin
						ri_q    <= ri_q + 1'b1;
						state_q <= S_RM_RD;
					end else begin
						st_q    <= ST_MISSING;
						state_q <= S_EMIT1;
					end
				end
				S_SH_RD: begin
					if (tbl_dec) begin
						st_q    <= ST_OK;
						cnt_q   <= view.fill - 5'd1;
						state_q <= S_EMIT1;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					ri_q    <= ri_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_G_RD: begin
					if (!list_end) begin
						state_q <= S_G_WR;
					end else if (all_q && 32'(gl_q) != NUM_LISTS - 1) begin
						gl_q <= gl_q + 1'b1;
						ri_q <= '0;
					end else begin
						state_q <= S_G_END;
					end
				end
				S_G_WR: begin
					n_q     <= n_q + 1'b1;
					ri_q    <= ri_q + 1'b1;
					state_q <= S_G_RD;
				end
				S_G_END: begin
					i_q         <= '0;
					k_q         <= '0;
					have_best_q <= 1'b0;
					have_prev_q <= 1'b0;
					if (n_q == '0) begin
						st_q    <= all_q ? ST_ALL_EMPTY : ST_OK;
						state_q <= S_EMIT1;
					end else if (sorted_q) begin
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_P_RD;
					end
				end
				S_P_RD: state_q <= S_P_OUT;
				S_P_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						has_value_q <= 1'b1;
						value_q     <= buf_rdata_q;
						count_q     <= cnt_q[3:0];
						last_q      <= (k_q + 1'b1 == n_q);
						k_q         <= k_q + 1'b1;
						state_q     <= (k_q + 1'b1 == n_q) ? S_IDLE : S_P_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_PREV;
				S_Q_PREV: begin
					if (!have_prev_q || cmp_lt) begin
						state_q <= S_Q_BEST;
					end else if (scan_more) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_Q_OUT;
					end
				end
				S_Q_BEST: begin
					if (!have_best_q || cmp_lt) begin
						best_q      <= cand;
						have_best_q <= 1'b1;
					end
					if (scan_more) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_Q_OUT;
					end
				end
				S_Q_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						has_value_q <= 1'b1;
						value_q     <= best_q.v;
						count_q     <= cnt_q[3:0];
						last_q      <= (k_q + 1'b1 == n_q);
						prev_q      <= best_q;
						have_prev_q <= 1'b1;
						have_best_q <= 1'b0;
						i_q         <= '0;
						k_q         <= k_q + 1'b1;
						state_q     <= (k_q + 1'b1 == n_q) ? S_IDLE : S_Q_RD;
					end
				end
				S_EMIT1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						has_value_q <= 1'b0;
						value_q     <= '0;
						count_q     <= cnt_q[3:0];
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign has_value = has_value_q;
	assign value_res = value_q;
	assign count     = count_q;
	assign last      = last_q;

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_dec |-> view.fill != '0)
		else $error("fill decrement on an empty list");

	a_gather_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_G_WR |-> 32'(n_q) < DEPTH)
		else $error("gather overruns the readout buffer");

	a_sorted_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_Q_OUT |-> have_best_q)
		else $error("sorted result without a selected element");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DECIDE)
		else $error("accepted item not decoded");

endmodule
